FILE: src/rtnb_pkg.sv
package rtnb_pkg;

    // field widths
    localparam int CODE_W   = 32;
    localparam int INDEX_W  = 10;
    localparam int LEAF_W   = 11;

    // signed width of a table position, wide enough for the search overshoot
    localparam int POS_W    = 16;

    // common prefix length, -1 .. 64
    localparam int DELTA_W  = 8;
    localparam int LZC_W    = 6;

    // table depth default
    localparam int MAX_LEAVES_DEF = 1024;

    // leaf count after reset
    localparam logic [LEAF_W-1:0] LEAF_COUNT_RST = LEAF_W'(2);

    // stream widths, padded to whole bytes
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;

    // output tdata field offsets
    localparam int OUT_LC_LSB  = INDEX_W;
    localparam int OUT_LL_BIT  = OUT_LC_LSB + LEAF_W;
    localparam int OUT_RC_LSB  = OUT_LL_BIT + 1;
    localparam int OUT_RL_BIT  = OUT_RC_LSB + LEAF_W;

    // input kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic signed [DELTA_W-1:0] t_delta;

    // request to the shared prefix unit
    typedef struct packed {
        logic [INDEX_W-1:0] pos_a;
        t_pos               pos_b;
        t_pos               leaves;
        logic [CODE_W-1:0]  code_a;
        logic [CODE_W-1:0]  code_b;
    } t_prefix_req;

endpackage

FILE: src/radix_tree_node_builder_top.sv
// load transaction: no result, writes the code table, s_axis_tready stays high
// query transaction: each code table read passes the issue and done states (registered
//   read port), about 3*log2(leaf_count)+5 reads; a bad index skips the search and goes
//   straight to the push state; s_axis_tready is low while a query runs and while its
//   result waits for a stalled output register
// reset: i_rst_n is synchronous and active low, clears the sequencer, the output
//   valid and sets leaf_count to 2; the code table keeps its contents
module radix_tree_node_builder_top #(
    parameter int MAX_LEAVES = rtnb_pkg::MAX_LEAVES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [rtnb_pkg::LEAF_W-1:0]   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // index [9:0], code [41:10], zero pad [47:42]
    input  logic [rtnb_pkg::S_DATA_W-1:0] s_axis_tdata,
    // kind [0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // node_index [9:0], left_child [20:10], left_is_leaf [21], right_child [32:22],
    // right_is_leaf [33], zero pad [39:34]
    output logic [rtnb_pkg::M_DATA_W-1:0] m_axis_tdata,
    // bad_index [0]
    output logic                          m_axis_tuser
);

    localparam int AW = $clog2(MAX_LEAVES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DONE,
        ST_FINISH,
        ST_PUSH
    } t_state;

    typedef enum logic [2:0] {
        STEP_CODE,
        STEP_DP,
        STEP_DM,
        STEP_EXP,
        STEP_BIN,
        STEP_DN,
        STEP_SPL
    } t_step;

    function automatic rtnb_pkg::t_pos f_offs(
        input logic [rtnb_pkg::INDEX_W-1:0] base,
        input logic [rtnb_pkg::POS_W-1:0]   x,
        input logic                         neg
    );
        rtnb_pkg::t_pos b;
        b = rtnb_pkg::t_pos'(base);
        return neg ? b - rtnb_pkg::t_pos'(x) : b + rtnb_pkg::t_pos'(x);
    endfunction

    // code table
    logic [rtnb_pkg::CODE_W-1:0] r_mem [MAX_LEAVES];
    logic [rtnb_pkg::CODE_W-1:0] r_rdata;

    logic [rtnb_pkg::LEAF_W-1:0]  r_leaf_count;
    t_state                       r_state;
    t_step                        r_step;
    logic [rtnb_pkg::INDEX_W-1:0] r_i;
    logic [rtnb_pkg::CODE_W-1:0]  r_code_i;
    rtnb_pkg::t_pos               r_pos;
    rtnb_pkg::t_delta             r_dp;
    rtnb_pkg::t_delta             r_mind;
    rtnb_pkg::t_delta             r_dnode;
    logic                         r_neg;
    logic [rtnb_pkg::POS_W-1:0]   r_lmax;
    logic [rtnb_pkg::POS_W-1:0]   r_l;
    logic [rtnb_pkg::POS_W-1:0]   r_t;
    logic [rtnb_pkg::POS_W-1:0]   r_s;
    logic [rtnb_pkg::M_DATA_W-1:0] r_res_data;
    logic                          r_res_bad;
    logic [rtnb_pkg::M_DATA_W-1:0] r_out_data;
    logic                          r_out_bad;
    logic                          r_out_valid;

    logic [rtnb_pkg::INDEX_W-1:0] w_in_index;
    logic [rtnb_pkg::CODE_W-1:0]  w_in_code;
    logic                         w_in_fire;
    rtnb_pkg::t_pos               w_n;
    rtnb_pkg::t_prefix_req        w_req;
    rtnb_pkg::t_delta             w_delta;
    logic                         w_hit_mind;
    logic                         w_hit_dnode;
    logic [rtnb_pkg::POS_W-1:0]   w_l_new;
    logic [rtnb_pkg::POS_W-1:0]   w_t_half;
    logic [rtnb_pkg::POS_W-1:0]   w_s_new;
    logic [rtnb_pkg::POS_W-1:0]   w_t_ceil;
    logic                         w_dm_neg;
    rtnb_pkg::t_pos               w_j;
    rtnb_pkg::t_pos               w_split;
    rtnb_pkg::t_pos               w_lo;
    rtnb_pkg::t_pos               w_hi;
    rtnb_pkg::t_pos               w_lc;
    rtnb_pkg::t_pos               w_rc;
    logic                         w_ll;
    logic                         w_rl;

    assign w_in_index = s_axis_tdata[rtnb_pkg::INDEX_W-1:0];
    assign w_in_code  = s_axis_tdata[rtnb_pkg::INDEX_W +: rtnb_pkg::CODE_W];
    assign w_in_fire  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_bad;

    // leaf count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= rtnb_pkg::LEAF_COUNT_RST;
        end else if (i_cfg_wen) begin
            r_leaf_count <= i_cfg_wdata;
        end
    end

    // leaf count clamped to 2 .. MAX_LEAVES
    always_comb begin
        if (r_leaf_count < rtnb_pkg::LEAF_W'(2)) begin
            w_n = rtnb_pkg::t_pos'(2);
        end else if (32'(r_leaf_count) > MAX_LEAVES) begin
            w_n = rtnb_pkg::t_pos'(MAX_LEAVES);
        end else begin
            w_n = rtnb_pkg::t_pos'(r_leaf_count);
        end
    end

    // table write on load, registered read at the search position
    always_ff @(posedge i_clk) begin
        if (w_in_fire && (s_axis_tuser == rtnb_pkg::KIND_LOAD)
                && (32'(w_in_index) < MAX_LEAVES)) begin
            r_mem[AW'(w_in_index)] <= w_in_code;
        end
        r_rdata <= r_mem[r_pos[AW-1:0]];
    end

    // shared prefix length unit
    assign w_req.pos_a  = r_i;
    assign w_req.pos_b  = r_pos;
    assign w_req.leaves = w_n;
    assign w_req.code_a = r_code_i;
    assign w_req.code_b = r_rdata;

    rtnb_prefix_unit u_prefix (
        .i_req   (w_req),
        .o_delta (w_delta)
    );

    // search step arithmetic
    assign w_hit_mind  = (w_delta > r_mind);
    assign w_hit_dnode = (w_delta > r_dnode);
    assign w_l_new     = w_hit_mind ? r_l + r_t : r_l;
    assign w_t_half    = r_t >> 1;
    assign w_s_new     = w_hit_dnode ? r_s + r_t : r_s;
    assign w_t_ceil    = (r_t + rtnb_pkg::POS_W'(1)) >> 1;
    assign w_dm_neg    = (r_dp < w_delta);

    // children from split and range ends
    always_comb begin
        w_j     = f_offs(r_i, r_l, r_neg);
        w_split = f_offs(r_i, r_s, r_neg) - (r_neg ? rtnb_pkg::t_pos'(1) : '0);
        w_lo    = (rtnb_pkg::t_pos'(r_i) < w_j) ? rtnb_pkg::t_pos'(r_i) : w_j;
        w_hi    = (rtnb_pkg::t_pos'(r_i) > w_j) ? rtnb_pkg::t_pos'(r_i) : w_j;
        w_ll    = (w_lo == w_split);
        w_rl    = (w_hi == w_split + rtnb_pkg::t_pos'(1));
        w_lc    = w_ll ? w_split + w_n - rtnb_pkg::t_pos'(1) : w_split;
        w_rc    = w_rl ? w_split + w_n : w_split + rtnb_pkg::t_pos'(1);
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_CODE;
            r_out_valid <= 1'b0;
        end else begin
            // output register empties when taken, the push state refills it
            if (m_axis_tready && (r_state != ST_PUSH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire && (s_axis_tuser == rtnb_pkg::KIND_QUERY)) begin
                        r_i <= w_in_index;
                        if (rtnb_pkg::t_pos'(w_in_index) >= w_n - rtnb_pkg::t_pos'(1)) begin
                            r_res_data <= rtnb_pkg::M_DATA_W'(w_in_index);
                            r_res_bad  <= 1'b1;
                            r_state    <= ST_PUSH;
                        end else begin
                            r_pos   <= rtnb_pkg::t_pos'(w_in_index);
                            r_step  <= STEP_CODE;
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_state <= ST_ISSUE;
                    unique case (r_step)
                        STEP_CODE: begin
                            r_code_i <= r_rdata;
                            r_pos    <= f_offs(r_i, rtnb_pkg::POS_W'(1), 1'b0);
                            r_step   <= STEP_DP;
                        end
                        STEP_DP: begin
                            r_dp   <= w_delta;
                            r_pos  <= f_offs(r_i, rtnb_pkg::POS_W'(1), 1'b1);
                            r_step <= STEP_DM;
                        end
                        STEP_DM: begin
                            // direction toward the longer common prefix
                            r_neg  <= w_dm_neg;
                            r_mind <= w_dm_neg ? r_dp : w_delta;
                            r_lmax <= rtnb_pkg::POS_W'(2);
                            r_pos  <= f_offs(r_i, rtnb_pkg::POS_W'(2), w_dm_neg);
                            r_step <= STEP_EXP;
                        end
                        STEP_EXP: begin
                            // exponential search for an upper bound
                            if (w_delta > r_mind) begin
                                r_lmax <= r_lmax << 1;
                                r_pos  <= f_offs(r_i, r_lmax << 1, r_neg);
                            end else begin
                                r_l    <= '0;
                                r_t    <= r_lmax >> 1;
                                r_pos  <= f_offs(r_i, r_lmax >> 1, r_neg);
                                r_step <= STEP_BIN;
                            end
                        end
                        STEP_BIN: begin
                            // binary search for the far end of the range
                            r_l <= w_l_new;
                            r_t <= w_t_half;
                            if (w_t_half != '0) begin
                                r_pos <= f_offs(r_i, w_l_new + w_t_half, r_neg);
                            end else begin
                                r_pos  <= f_offs(r_i, w_l_new, r_neg);
                                r_step <= STEP_DN;
                            end
                        end
                        STEP_DN: begin
                            r_dnode <= w_delta;
                            r_s     <= '0;
                            if (r_l != '0) begin
                                r_t    <= (r_l + rtnb_pkg::POS_W'(1)) >> 1;
                                r_pos  <= f_offs(r_i, (r_l + rtnb_pkg::POS_W'(1)) >> 1, r_neg);
                                r_step <= STEP_SPL;
                            end else begin
                                r_state <= ST_FINISH;
                            end
                        end
                        STEP_SPL: begin
                            // split search with ceil halving steps
                            r_s <= w_s_new;
                            if (r_t <= rtnb_pkg::POS_W'(1)) begin
                                r_state <= ST_FINISH;
                            end else begin
                                r_t   <= w_t_ceil;
                                r_pos <= f_offs(r_i, w_s_new + w_t_ceil, r_neg);
                            end
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_FINISH: begin
                    r_res_data <= {
                        rtnb_pkg::M_DATA_W'(0)
                            | (rtnb_pkg::M_DATA_W'(w_rl) << rtnb_pkg::OUT_RL_BIT)
                            | (rtnb_pkg::M_DATA_W'(w_rc[rtnb_pkg::LEAF_W-1:0])
                                << rtnb_pkg::OUT_RC_LSB)
                            | (rtnb_pkg::M_DATA_W'(w_ll) << rtnb_pkg::OUT_LL_BIT)
                            | (rtnb_pkg::M_DATA_W'(w_lc[rtnb_pkg::LEAF_W-1:0])
                                << rtnb_pkg::OUT_LC_LSB)
                            | rtnb_pkg::M_DATA_W'(r_i)
                    };
                    r_res_bad <= 1'b0;
                    r_state   <= ST_PUSH;
                end
                ST_PUSH: begin
                    // hand the result to the output register once it is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res_data;
                        r_out_bad   <= r_res_bad;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/rtnb_prefix_unit.sv
module rtnb_prefix_unit (
    input  rtnb_pkg::t_prefix_req i_req,
    output rtnb_pkg::t_delta      o_delta
);

    // leading-zero count by five halving steps
    function automatic logic [rtnb_pkg::LZC_W-1:0] f_lzc(input logic [31:0] v);
        logic [31:0]               x;
        logic [rtnb_pkg::LZC_W-1:0] n;
        x = v;
        n = '0;
        if (v == 32'd0) begin
            n = rtnb_pkg::LZC_W'(32);
        end else begin
            if (x[31:16] == 16'd0) begin
                n[4] = 1'b1;
                x = x << 16;
            end
            if (x[31:24] == 8'd0) begin
                n[3] = 1'b1;
                x = x << 8;
            end
            if (x[31:28] == 4'd0) begin
                n[2] = 1'b1;
                x = x << 4;
            end
            if (x[31:30] == 2'd0) begin
                n[1] = 1'b1;
                x = x << 2;
            end
            if (x[31] == 1'b0) begin
                n[0] = 1'b1;
            end
        end
        return n;
    endfunction

    logic [rtnb_pkg::CODE_W-1:0] w_code_x;
    logic [31:0]                 w_idx_x;
    logic                        w_oob;
    logic [rtnb_pkg::LZC_W-1:0]  w_lz_code;
    logic [rtnb_pkg::LZC_W-1:0]  w_lz_idx;

    // neighbour outside the table counts as -1
    assign w_oob = (i_req.pos_b < 0) || (i_req.pos_b >= i_req.leaves);

    assign w_code_x = i_req.code_a ^ i_req.code_b;
    assign w_idx_x  = 32'(i_req.pos_a) ^ 32'(unsigned'(i_req.pos_b));

    assign w_lz_code = f_lzc(w_code_x);
    assign w_lz_idx  = f_lzc(w_idx_x);

    // equal codes are told apart by their indices
    always_comb begin
        if (w_oob) begin
            o_delta = -rtnb_pkg::t_delta'(1);
        end else if (w_code_x == '0) begin
            o_delta = rtnb_pkg::t_delta'(32) + rtnb_pkg::t_delta'(w_lz_idx);
        end else begin
            o_delta = rtnb_pkg::t_delta'(w_lz_code);
        end
    end

endmodule

FILE: src/rtnb_checker.sv
module rtnb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rtnb_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);

    logic w_in_fire;
    assign w_in_fire = s_axis_tvalid && s_axis_tready;

    // a result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a load transaction never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && (s_axis_tuser == rtnb_pkg::KIND_LOAD) |=> !$rose(m_axis_tvalid))
        else $error("result after a load");

    // a query keeps the input side closed while it runs
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && (s_axis_tuser == rtnb_pkg::KIND_QUERY) |=> !s_axis_tready)
        else $error("input taken during a query");

    // a bad index reports zero children
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser
            |-> m_axis_tdata[rtnb_pkg::M_DATA_W-1:rtnb_pkg::INDEX_W] == '0)
        else $error("bad index with children");

endmodule

bind radix_tree_node_builder_top rtnb_checker u_rtnb_checker (.*);
